### rtl/core/satc_pkg.sv
// shared types and constants for the set-associative cache tag and policy block
`timescale 1ns / 1ps
`default_nettype none

package satc_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_LOG2_SETS        = 3'd0;
  localparam logic [2:0] CFG_LOG2_WAYS        = 3'd1;
  localparam logic [2:0] CFG_LOG2_BLOCK_BYTES = 3'd2;
  localparam logic [2:0] CFG_WRITE_ALLOCATE   = 3'd3;
  localparam logic [2:0] CFG_WRITE_BACK       = 3'd4;
  localparam logic [2:0] CFG_EVICTION_LRU     = 3'd5;

  // block size limits in log2 bytes
  localparam logic [3:0] LB_MIN = 4'd2;
  localparam logic [3:0] LB_MAX = 4'd12;

  // modeled costs
  localparam logic [17:0] COST_HIT        = 18'd1;
  localparam logic [17:0] COST_MEM_WORD   = 18'd100;
  localparam logic [17:0] COST_WRITE_AROUND = 18'd101;

  localparam int TAG_W   = 30;
  localparam int STAMP_W = 32;
  localparam int COST_W  = 18;
  localparam int CNT_W   = 32;

  // one way of a set as kept in the tag memory
  typedef struct packed {
    logic               valid;
    logic               dirty;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] fill_stamp;
    logic [STAMP_W-1:0] use_stamp;
  } way_entry_t;

  // what the cost unit needs to know about one access
  typedef struct packed {
    logic       hit;
    logic       store;
    logic       write_around;
    logic       dirty_ev;
    logic       write_back;
    logic [3:0] lb;
  } cost_req_t;

endpackage

`default_nettype wire

### rtl/core/set_assoc_cache_tag_policy.sv
// top level: tag memory, lookup, victim scan, write-back of the set and statistics
// a miss into a full set runs the victim scan; a hit, an empty way filled, or a store
//   written around commits straight from the lookup
// throughput: one access at a time; busy stays high from accept until the result
//   beat, the victim scan compares one way per cycle from the set's row register
// reset: synchronous; a clearing pass writes every set row of the tag memory,
//   with busy high; config registers return to defaults at once
// results cannot be stalled: out_valid is high for exactly one cycle per access
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_cache_tag_policy #(
  parameter int MAX_SETS = 256,
  parameter int MAX_WAYS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // command channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_action,
  input  wire logic [31:0] in_address,
  // config write port
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [3:0]  cfg_data,
  // result channel
  output logic             out_valid,
  output logic             out_hit,
  output logic             out_filled,
  output logic             out_dirty_eviction,
  output logic [17:0]      out_access_cycles,
  output logic [31:0]      out_load_count,
  output logic [31:0]      out_store_count,
  output logic [31:0]      out_load_hit_count,
  output logic [31:0]      out_load_miss_count,
  output logic [31:0]      out_store_hit_count,
  output logic [31:0]      out_store_miss_count,
  output logic [31:0]      out_cycle_count
);

  localparam int SET_LG = $clog2(MAX_SETS + 1) - 1;
  localparam int WAY_LG = $clog2(MAX_WAYS + 1) - 1;
  localparam int SET_AW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  typedef satc_pkg::way_entry_t [MAX_WAYS-1:0] row_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  // config registers
  logic [3:0] log2_sets_r;
  logic [1:0] log2_ways_r;
  logic [3:0] log2_block_bytes_r;
  logic       write_allocate_r;
  logic       write_back_r;
  logic       eviction_lru_r;

  state_t                          state_r;
  logic [SET_AW-1:0]               clr_idx_r;
  logic [SET_AW-1:0]               set_r;
  logic [satc_pkg::TAG_W-1:0]      tag_r;
  logic                            store_r;
  logic [WAY_W-1:0]                scan_idx_r;
  logic [WAY_W-1:0]                vict_r;
  logic [satc_pkg::STAMP_W-1:0]    best_r;
  logic [satc_pkg::STAMP_W-1:0]    stamp_r;
  row_t                            row_r;

  logic [satc_pkg::CNT_W-1:0] load_cnt_r, store_cnt_r, lhit_cnt_r, lmiss_cnt_r;
  logic [satc_pkg::CNT_W-1:0] shit_cnt_r, smiss_cnt_r, cyc_cnt_r;

  logic                       out_valid_r, out_hit_r, out_filled_r, out_dirty_r;
  logic [satc_pkg::COST_W-1:0] out_cost_r;

  row_t mem [MAX_SETS];

  // config write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log2_sets_r        <= 4'd8;
      log2_ways_r        <= 2'd3;
      log2_block_bytes_r <= 4'd4;
      write_allocate_r   <= 1'b1;
      write_back_r       <= 1'b0;
      eviction_lru_r     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        satc_pkg::CFG_LOG2_SETS:        log2_sets_r        <= cfg_data;
        satc_pkg::CFG_LOG2_WAYS:        log2_ways_r        <= cfg_data[1:0];
        satc_pkg::CFG_LOG2_BLOCK_BYTES: log2_block_bytes_r <= cfg_data;
        satc_pkg::CFG_WRITE_ALLOCATE:   write_allocate_r   <= cfg_data[0];
        satc_pkg::CFG_WRITE_BACK:       write_back_r       <= cfg_data[0];
        satc_pkg::CFG_EVICTION_LRU:     eviction_lru_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // geometry clipped to what the memory holds
  logic [3:0]       ls_c;
  logic [2:0]       lw_c;
  logic [3:0]       lb_c;
  logic [WAY_W:0]   way_cnt_c;
  logic [WAY_W-1:0] way_last_c;

  always_comb begin
    ls_c = (log2_sets_r > 4'(SET_LG)) ? 4'(SET_LG) : log2_sets_r;
    lw_c = ({1'b0, log2_ways_r} > 3'(WAY_LG)) ? 3'(WAY_LG) : {1'b0, log2_ways_r};
    if (log2_block_bytes_r < satc_pkg::LB_MIN) begin
      lb_c = satc_pkg::LB_MIN;
    end else if (log2_block_bytes_r > satc_pkg::LB_MAX) begin
      lb_c = satc_pkg::LB_MAX;
    end else begin
      lb_c = log2_block_bytes_r;
    end
    way_cnt_c  = (WAY_W+1)'(1) << lw_c;
    way_last_c = WAY_W'(way_cnt_c - (WAY_W+1)'(1));
  end

  // address split into set and tag
  logic              accept;
  logic [31:0]       block_c;
  logic [31:0]       set_mask_c;
  logic [SET_AW-1:0] set_c;
  logic [satc_pkg::TAG_W-1:0] tag_c;

  assign accept     = start && !busy;
  assign block_c    = in_address >> lb_c;
  assign set_mask_c = 32'((33'd1 << ls_c) - 33'd1);
  assign set_c      = SET_AW'(block_c & set_mask_c);
  assign tag_c      = satc_pkg::TAG_W'(block_c >> ls_c);

  // tag match and first empty way over the registered row
  logic             hit_c, empty_found_c;
  logic [WAY_W-1:0] hit_way_c, empty_way_c;

  always_comb begin
    hit_c         = 1'b0;
    hit_way_c     = '0;
    empty_found_c = 1'b0;
    empty_way_c   = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if ((WAY_W+1)'(w) < way_cnt_c) begin
        if (row_r[w].valid && row_r[w].tag == tag_r) begin
          hit_c     = 1'b1;
          hit_way_c = WAY_W'(w);
        end
        if (!row_r[w].valid) begin
          empty_found_c = 1'b1;
          empty_way_c   = WAY_W'(w);
        end
      end
    end
  end

  // victim scan compare, one way per cycle
  logic [satc_pkg::STAMP_W-1:0] scan_stamp_c;
  logic [satc_pkg::STAMP_W-1:0] first_stamp_c;

  assign scan_stamp_c  = eviction_lru_r ? row_r[scan_idx_r].use_stamp :
                                          row_r[scan_idx_r].fill_stamp;
  assign first_stamp_c = eviction_lru_r ? row_r[0].use_stamp : row_r[0].fill_stamp;

  // commit decision
  logic             write_around_c, need_scan_c, commit_en, commit_hit, commit_fill;
  logic             dirty_ev_c;
  logic [WAY_W-1:0] commit_way;

  assign write_around_c = store_r && !write_allocate_r && !hit_c;
  assign need_scan_c    = !hit_c && !write_around_c && !empty_found_c;
  assign commit_en      = (state_r == ST_LOOKUP && !need_scan_c) || (state_r == ST_COMMIT);
  assign commit_hit     = (state_r == ST_LOOKUP) && hit_c;
  assign commit_fill    = commit_en && !commit_hit &&
                          !((state_r == ST_LOOKUP) && write_around_c);
  assign commit_way     = (state_r == ST_COMMIT) ? vict_r :
                          (hit_c ? hit_way_c : empty_way_c);
  assign dirty_ev_c     = (state_r == ST_COMMIT) && row_r[vict_r].dirty;

  // cost of the access
  satc_pkg::cost_req_t          cost_req;
  logic [satc_pkg::COST_W-1:0]  cost_c;

  always_comb begin
    cost_req.hit          = commit_hit;
    cost_req.store        = store_r;
    cost_req.write_around = commit_en && !commit_hit && !commit_fill;
    cost_req.dirty_ev     = dirty_ev_c;
    cost_req.write_back   = write_back_r;
    cost_req.lb           = lb_c;
  end

  satc_cost u_cost (
    .req  (cost_req),
    .cost (cost_c)
  );

  // modified row for write-back
  row_t                 row_nxt;
  satc_pkg::way_entry_t entry_c;

  always_comb begin
    entry_c = row_r[commit_way];
    entry_c.use_stamp = stamp_r;
    if (commit_fill) begin
      entry_c.valid      = 1'b1;
      entry_c.tag        = tag_r;
      entry_c.fill_stamp = stamp_r;
      entry_c.dirty      = store_r && write_back_r;
    end else if (store_r && write_back_r) begin
      entry_c.dirty = 1'b1;
    end
    row_nxt             = row_r;
    row_nxt[commit_way] = entry_c;
  end

  // tag memory: one row per set, registered read
  logic              mem_we;
  logic [SET_AW-1:0] mem_waddr;
  row_t              mem_wdata;

  always_comb begin
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_r;
      mem_wdata = '0;
    end else begin
      mem_we    = commit_hit || commit_fill;
      mem_waddr = set_r;
      mem_wdata = row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      row_r <= mem[set_c];
    end
  end

  // control, scan, stamps, statistics and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      set_r       <= '0;
      tag_r       <= '0;
      store_r     <= 1'b0;
      scan_idx_r  <= '0;
      vict_r      <= '0;
      best_r      <= '0;
      stamp_r     <= 32'd1;
      load_cnt_r  <= '0;
      store_cnt_r <= '0;
      lhit_cnt_r  <= '0;
      lmiss_cnt_r <= '0;
      shit_cnt_r  <= '0;
      smiss_cnt_r <= '0;
      cyc_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      out_hit_r   <= 1'b0;
      out_filled_r <= 1'b0;
      out_dirty_r <= 1'b0;
      out_cost_r  <= '0;
    end else begin
      out_valid_r <= commit_en;
      case (state_r)
        ST_CLEAR: begin
          clr_idx_r <= clr_idx_r + SET_AW'(1);
          if (clr_idx_r == SET_AW'(MAX_SETS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            set_r   <= set_c;
            tag_r   <= tag_c;
            store_r <= in_action;
            state_r <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          if (need_scan_c) begin
            vict_r     <= '0;
            best_r     <= first_stamp_c;
            scan_idx_r <= WAY_W'(1);
            state_r    <= (way_last_c == '0) ? ST_COMMIT : ST_SCAN;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (scan_stamp_c < best_r) begin
            vict_r <= scan_idx_r;
            best_r <= scan_stamp_c;
          end
          scan_idx_r <= scan_idx_r + WAY_W'(1);
          if (scan_idx_r == way_last_c) begin
            state_r <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase

      // per-access bookkeeping at commit
      if (commit_en) begin
        if (commit_hit || commit_fill) begin
          stamp_r <= stamp_r + 32'd1;
        end
        if (store_r) begin
          store_cnt_r <= store_cnt_r + 32'd1;
          if (commit_hit) begin
            shit_cnt_r <= shit_cnt_r + 32'd1;
          end else begin
            smiss_cnt_r <= smiss_cnt_r + 32'd1;
          end
        end else begin
          load_cnt_r <= load_cnt_r + 32'd1;
          if (commit_hit) begin
            lhit_cnt_r <= lhit_cnt_r + 32'd1;
          end else begin
            lmiss_cnt_r <= lmiss_cnt_r + 32'd1;
          end
        end
        cyc_cnt_r    <= cyc_cnt_r + 32'(cost_c);
        out_hit_r    <= commit_hit;
        out_filled_r <= commit_fill;
        out_dirty_r  <= dirty_ev_c;
        out_cost_r   <= cost_c;
      end
    end
  end

  assign busy                 = (state_r != ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_hit              = out_hit_r;
  assign out_filled           = out_filled_r;
  assign out_dirty_eviction   = out_dirty_r;
  assign out_access_cycles    = out_cost_r;
  assign out_load_count       = load_cnt_r;
  assign out_store_count      = store_cnt_r;
  assign out_load_hit_count   = lhit_cnt_r;
  assign out_load_miss_count  = lmiss_cnt_r;
  assign out_store_hit_count  = shit_cnt_r;
  assign out_store_miss_count = smiss_cnt_r;
  assign out_cycle_count      = cyc_cnt_r;

  // a hit never fills or evicts
  a_hit_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_filled && !out_dirty_eviction)
    else $error("hit beat reports fill or eviction");

  // a dirty eviction only comes with a fill
  a_evict_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dirty_eviction |-> out_filled)
    else $error("dirty eviction without fill");

  // stamp advances exactly when a line is touched
  a_stamp_step: assert property (@(posedge clk) disable iff (!rst_n)
    commit_en && (commit_hit || commit_fill) |=> stamp_r == $past(stamp_r) + 32'd1)
    else $error("stamp did not advance on line access");

  // result beat follows a commit cycle and nothing else
  a_beat_commit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_LOOKUP || state_r == ST_COMMIT))
    else $error("result beat without commit");

endmodule

`default_nettype wire

### rtl/core/satc_cost.sv
// modeled cycle cost of one access
`timescale 1ns / 1ps
`default_nettype none

module satc_cost (
  input  satc_pkg::cost_req_t          req,
  output logic [satc_pkg::COST_W-1:0]  cost
);

  logic [satc_pkg::COST_W-1:0] fill_cost;
  logic [satc_pkg::COST_W-1:0] base_cost;
  logic [satc_pkg::COST_W-1:0] evict_cost;
  logic [satc_pkg::COST_W-1:0] wt_cost;
  logic [3:0]                  words_lg;

  // memory transfer cost scales with words per block
  assign words_lg  = req.lb - satc_pkg::LB_MIN;
  assign fill_cost = satc_pkg::COST_MEM_WORD << words_lg;

  // hit, write around or fill, then dirty victim and write-through extras
  always_comb begin
    if (req.hit) begin
      base_cost = satc_pkg::COST_HIT;
    end else if (req.write_around) begin
      base_cost = satc_pkg::COST_WRITE_AROUND;
    end else begin
      base_cost = fill_cost + satc_pkg::COST_HIT;
    end
    evict_cost = (req.dirty_ev && !req.hit && !req.write_around) ? fill_cost : '0;
    wt_cost    = (req.store && !req.write_back && !req.write_around) ?
                 satc_pkg::COST_MEM_WORD : '0;
  end

  assign cost = base_cost + evict_cost + wt_cost;

endmodule

`default_nettype wire

### sim/tb.sv
// self-checking testbench for the set-associative cache tag and policy block
`timescale 1ns / 1ps

module tb;

  localparam int MAX_SETS       = 256;
  localparam int MAX_WAYS       = 8;
  localparam int LINE_COUNT     = MAX_SETS * MAX_WAYS;
  localparam int RANDOM_ITEMS   = 1080;
  localparam int DRAIN_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam bit ACT_LOAD       = 1'b0;
  localparam bit ACT_STORE      = 1'b1;
  // indexes past the last register, writes there are ignored
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  typedef struct {
    logic        hit;
    logic        filled;
    logic        dirty_eviction;
    logic [17:0] access_cycles;
    logic [31:0] load_count;
    logic [31:0] store_count;
    logic [31:0] load_hit_count;
    logic [31:0] load_miss_count;
    logic [31:0] store_hit_count;
    logic [31:0] store_miss_count;
    logic [31:0] cycle_count;
  } access_result_t;

  // tag store, policy and statistics as the block should keep them
  class cache_policy_model;
    bit [29:0]   line_tag   [LINE_COUNT];
    bit          line_valid [LINE_COUNT];
    bit          line_dirty [LINE_COUNT];
    bit [31:0]   fill_stamp [LINE_COUNT];
    bit [31:0]   use_stamp  [LINE_COUNT];
    bit [31:0]   stamp_next;
    bit [31:0]   loads, stores, ld_hit_total, ld_miss_total, st_hit_total, st_miss_total;
    bit [31:0]   cycle_total;
    bit [3:0]    log2_sets_r, log2_block_r;
    bit [1:0]    log2_ways_r;
    bit          write_allocate_r, write_back_r, evict_lru_r;
    access_result_t expected_results[$];
    int unsigned mismatch_count, accesses_seen, hits_seen, fills_seen;
    int unsigned dirty_evictions_seen, write_arounds_seen;

    function new();
      stamp_next       = 32'd1;
      log2_sets_r      = 4'd8;
      log2_ways_r      = 2'd3;
      log2_block_r     = 4'd4;
      write_allocate_r = 1'b1;
      write_back_r     = 1'b0;
      evict_lru_r      = 1'b1;
    endfunction

    function int unsigned fit_log2(int unsigned lg, int unsigned limit);
      while (lg > 0 && (1 << lg) > limit) lg--;
      return lg;
    endfunction

    function int unsigned block_log2(bit [3:0] lg);
      if (lg < satc_pkg::LB_MIN) return satc_pkg::LB_MIN;
      if (lg > satc_pkg::LB_MAX) return satc_pkg::LB_MAX;
      return lg;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function void note_config(logic [2:0] idx, logic [3:0] data);
      case (idx)
        satc_pkg::CFG_LOG2_SETS:        log2_sets_r      = data;
        satc_pkg::CFG_LOG2_WAYS:        log2_ways_r      = data[1:0];
        satc_pkg::CFG_LOG2_BLOCK_BYTES: log2_block_r     = data;
        satc_pkg::CFG_WRITE_ALLOCATE:   write_allocate_r = data[0];
        satc_pkg::CFG_WRITE_BACK:       write_back_r     = data[0];
        satc_pkg::CFG_EVICTION_LRU:     evict_lru_r      = data[0];
        default: ;
      endcase
    endfunction

    // one access: lookup, victim choice, line update and cost
    function access_result_t predict_access(bit is_store, bit [31:0] addr);
      access_result_t r;
      int unsigned ls, lw, lb, nways, set_idx, base, w, way;
      bit [31:0]   blk, fill_cost, cost, key_a, key_b;
      bit [29:0]   tag;
      bit          hit, filled, dirty_ev, found;
      ls        = fit_log2(log2_sets_r, MAX_SETS);
      lw        = fit_log2(log2_ways_r, MAX_WAYS);
      lb        = block_log2(log2_block_r);
      nways     = 1 << lw;
      blk       = addr >> lb;
      set_idx   = blk & ((1 << ls) - 1);
      tag       = 30'(blk >> ls);
      base      = set_idx * MAX_WAYS;
      fill_cost = 32'(satc_pkg::COST_MEM_WORD) * ((32'd1 << lb) >> 2);
      cost      = 0;
      hit       = 1'b0;
      filled    = 1'b0;
      dirty_ev  = 1'b0;
      found     = 1'b0;
      way       = 0;

      if (is_store) stores++;
      else loads++;

      for (w = 0; w < nways; w++) begin
        if (line_valid[base + w] && line_tag[base + w] == tag) begin
          hit = 1'b1;
          way = w;
          break;
        end
      end

      if (hit) begin
        if (is_store) st_hit_total++;
        else ld_hit_total++;
        use_stamp[base + way] = stamp_next;
        stamp_next++;
        cost = 32'(satc_pkg::COST_HIT);
        if (is_store) begin
          if (write_back_r) line_dirty[base + way] = 1'b1;
          else cost += 32'(satc_pkg::COST_MEM_WORD);
        end
      end else begin
        if (is_store) st_miss_total++;
        else ld_miss_total++;
        if (is_store && !write_allocate_r) begin
          cost = 32'(satc_pkg::COST_WRITE_AROUND);
          write_arounds_seen++;
        end else begin
          // first empty way, else the way with the smallest stamp
          for (w = 0; w < nways; w++) begin
            if (!line_valid[base + w]) begin
              way   = w;
              found = 1'b1;
              break;
            end
          end
          if (!found) begin
            way = 0;
            for (w = 1; w < nways; w++) begin
              key_a = evict_lru_r ? use_stamp[base + w] : fill_stamp[base + w];
              key_b = evict_lru_r ? use_stamp[base + way] : fill_stamp[base + way];
              if (key_a < key_b) way = w;
            end
            if (line_dirty[base + way]) begin
              dirty_ev = 1'b1;
              cost += fill_cost;
            end
          end
          cost += fill_cost + 1;
          filled = 1'b1;
          line_valid[base + way] = 1'b1;
          line_tag[base + way]   = tag;
          fill_stamp[base + way] = stamp_next;
          use_stamp[base + way]  = stamp_next;
          line_dirty[base + way] = 1'b0;
          stamp_next++;
          if (is_store) begin
            if (write_back_r) line_dirty[base + way] = 1'b1;
            else cost += 32'(satc_pkg::COST_MEM_WORD);
          end
        end
      end
      cycle_total += cost;

      if (hit) hits_seen++;
      if (filled) fills_seen++;
      if (dirty_ev) dirty_evictions_seen++;

      r.hit              = hit;
      r.filled           = filled;
      r.dirty_eviction   = dirty_ev;
      r.access_cycles    = cost[17:0];
      r.load_count       = loads;
      r.store_count      = stores;
      r.load_hit_count   = ld_hit_total;
      r.load_miss_count  = ld_miss_total;
      r.store_hit_count  = st_hit_total;
      r.store_miss_count = st_miss_total;
      r.cycle_count      = cycle_total;
      return r;
    endfunction

    function void note_access(bit is_store, bit [31:0] addr);
      expected_results.push_back(predict_access(is_store, addr));
      accesses_seen++;
    endfunction

    function void compare_field(string name, logic [31:0] expected_v, logic [31:0] actual_v);
      if (actual_v !== expected_v) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t ns  %s: expected 0x%0h, got 0x%0h", $time, name, expected_v,
                   actual_v);
      end
    endfunction

    function void check_result(access_result_t got);
      access_result_t want;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t ns  result beat with no access outstanding", $time);
        return;
      end
      want = expected_results.pop_front();
      compare_field("hit", 32'(want.hit), 32'(got.hit));
      compare_field("filled", 32'(want.filled), 32'(got.filled));
      compare_field("dirty_eviction", 32'(want.dirty_eviction), 32'(got.dirty_eviction));
      compare_field("access_cycles", 32'(want.access_cycles), 32'(got.access_cycles));
      compare_field("load_count", want.load_count, got.load_count);
      compare_field("store_count", want.store_count, got.store_count);
      compare_field("load_hit_count", want.load_hit_count, got.load_hit_count);
      compare_field("load_miss_count", want.load_miss_count, got.load_miss_count);
      compare_field("store_hit_count", want.store_hit_count, got.store_hit_count);
      compare_field("store_miss_count", want.store_miss_count, got.store_miss_count);
      compare_field("cycle_count", want.cycle_count, got.cycle_count);
    endfunction
  endclass

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        start       = 1'b0;
  logic        in_action   = 1'b0;
  logic [31:0] in_address  = 32'd0;
  logic        cfg_we      = 1'b0;
  logic [2:0]  cfg_index   = 3'd0;
  logic [3:0]  cfg_data    = 4'd0;
  logic        busy;
  logic        out_valid, out_hit, out_filled, out_dirty_eviction;
  logic [17:0] out_access_cycles;
  logic [31:0] out_load_count, out_store_count, out_load_hit_count, out_load_miss_count;
  logic [31:0] out_store_hit_count, out_store_miss_count, out_cycle_count;

  cache_policy_model model = new();
  bit          no_gaps = 1'b0;
  int unsigned settings_applied = 0;
  int unsigned idle_cycles = 0;

  set_assoc_cache_tag_policy #(
    .MAX_SETS(MAX_SETS),
    .MAX_WAYS(MAX_WAYS)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_action           (in_action),
    .in_address          (in_address),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_valid           (out_valid),
    .out_hit             (out_hit),
    .out_filled          (out_filled),
    .out_dirty_eviction  (out_dirty_eviction),
    .out_access_cycles   (out_access_cycles),
    .out_load_count      (out_load_count),
    .out_store_count     (out_store_count),
    .out_load_hit_count  (out_load_hit_count),
    .out_load_miss_count (out_load_miss_count),
    .out_store_hit_count (out_store_hit_count),
    .out_store_miss_count(out_store_miss_count),
    .out_cycle_count     (out_cycle_count)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // register writes and accepted accesses feed the model
  always @(posedge clk) begin
    if (rst_n && cfg_we) model.note_config(cfg_index, cfg_data);
    if (rst_n && start && !busy) model.note_access(in_action, in_address);
  end

  // result beats
  always @(posedge clk) begin
    access_result_t beat;
    if (rst_n && out_valid) begin
      beat.hit              = out_hit;
      beat.filled           = out_filled;
      beat.dirty_eviction   = out_dirty_eviction;
      beat.access_cycles    = out_access_cycles;
      beat.load_count       = out_load_count;
      beat.store_count      = out_store_count;
      beat.load_hit_count   = out_load_hit_count;
      beat.load_miss_count  = out_load_miss_count;
      beat.store_hit_count  = out_store_hit_count;
      beat.store_miss_count = out_store_miss_count;
      beat.cycle_count      = out_cycle_count;
      model.check_result(beat);
    end
  end

  // watchdog on cycles without an accepted access or a result beat
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles without a beat", idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // one access, held until the block takes it; start stays high across back-to-back beats
  task automatic drive_access(bit is_store, bit [31:0] addr);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_action  <= is_store;
    in_address <= addr;
    do @(posedge clk); while (busy);
  endtask

  // drop start and wait for every outstanding result
  task automatic settle_phase();
    start <= 1'b0;
    @(posedge clk);
    while (model.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [3:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic apply_settings(bit [3:0] sets_d, bit [1:0] ways_d, bit [3:0] lb_d,
                                bit [3:0] wa_d, bit [3:0] wb_d, bit [3:0] lru_d);
    write_reg(satc_pkg::CFG_LOG2_SETS, sets_d);
    write_reg(satc_pkg::CFG_LOG2_WAYS, {2'b00, ways_d});
    write_reg(satc_pkg::CFG_LOG2_BLOCK_BYTES, lb_d);
    write_reg(satc_pkg::CFG_WRITE_ALLOCATE, wa_d);
    write_reg(satc_pkg::CFG_WRITE_BACK, wb_d);
    write_reg(satc_pkg::CFG_EVICTION_LRU, lru_d);
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // random accesses mostly into a few sets with a tag pool a little larger than the ways
  task automatic run_random_phase(int unsigned n_items, bit [3:0] sets_d, bit [1:0] ways_d,
                                  bit [3:0] lb_d);
    bit [31:0]   set_pool [4];
    bit [31:0]   tag_pool [12];
    bit [31:0]   addr;
    int unsigned ls, lw, lb, pool_size, i;
    apply_settings(sets_d, ways_d, lb_d, 4'($urandom), 4'($urandom), 4'($urandom));
    ls        = model.fit_log2(sets_d, MAX_SETS);
    lw        = model.fit_log2(ways_d, MAX_WAYS);
    lb        = model.block_log2(lb_d);
    pool_size = (1 << lw) + 3;
    for (i = 0; i < 4; i++) set_pool[i] = $urandom & ((32'd1 << ls) - 1);
    for (i = 0; i < 12; i++) tag_pool[i] = (i < 4) ? i : $urandom;
    no_gaps = ($urandom_range(0, 3) == 0);
    for (i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < 15) begin
        addr = $urandom;
      end else begin
        addr = (tag_pool[$urandom_range(0, pool_size - 1)] << (ls + lb))
             | (set_pool[$urandom_range(0, 3)] << lb)
             | ($urandom & ((32'd1 << lb) - 1));
      end
      drive_access($urandom_range(0, 99) < 45, addr);
    end
    settle_phase();
  endtask

  initial begin
    int unsigned k, done, chunk, phase;
    bit [3:0]    sets_d, lb_d;
    bit [1:0]    ways_d;

    // reset, then wait out the clearing pass
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (!busy);
    do @(posedge clk); while (busy);

    // reset settings: hits, write-through stores, fills and lru evictions in set 0
    drive_access(ACT_LOAD, 32'h0000_0000);
    drive_access(ACT_LOAD, 32'h0000_000C);
    drive_access(ACT_STORE, 32'h0000_0000);
    drive_access(ACT_STORE, 32'hFFFF_FFFF);
    drive_access(ACT_LOAD, 32'hFFFF_FFF0);
    for (k = 1; k <= 8; k++) drive_access(ACT_LOAD, k << 12);
    drive_access(ACT_LOAD, 32'h0000_0000);
    settle_phase();

    // one way, oversized sets and block: write-around, write-back and dirty eviction
    apply_settings(4'd15, 2'd0, 4'd15, 4'b1110, 4'b0001, 4'b0000);
    drive_access(ACT_STORE, 32'h1234_5000);
    drive_access(ACT_LOAD, 32'h1234_5000);
    drive_access(ACT_STORE, 32'h1234_5ABC);
    drive_access(ACT_LOAD, 32'hABC4_5000);
    drive_access(ACT_STORE, 32'hABC4_5FFF);
    settle_phase();

    // write-through store miss over a dirty victim: the costliest access
    write_reg(satc_pkg::CFG_WRITE_BACK, 4'b0010);
    write_reg(satc_pkg::CFG_WRITE_ALLOCATE, 4'b1011);
    write_reg(CFG_SPARE_LO, 4'hF);
    write_reg(CFG_SPARE_HI, 4'hF);
    cfg_we <= 1'b0;
    drive_access(ACT_STORE, 32'h5554_5000);
    drive_access(ACT_LOAD, 32'h5554_5004);
    settle_phase();

    // random phases, the first two at the geometry extremes
    done  = 0;
    phase = 0;
    while (done < RANDOM_ITEMS) begin
      chunk = $urandom_range(60, 120);
      if (chunk > RANDOM_ITEMS - done) chunk = RANDOM_ITEMS - done;
      if (phase == 0) begin
        sets_d = 4'd0;
        ways_d = 2'd3;
        lb_d   = 4'd2;
      end else if (phase == 1) begin
        sets_d = 4'd8;
        ways_d = 2'd3;
        lb_d   = 4'd12;
      end else begin
        sets_d = ($urandom_range(0, 9) < 3) ? 4'($urandom_range(0, 15)) :
                                              4'($urandom_range(0, 3));
        ways_d = 2'($urandom_range(0, 3));
        lb_d   = ($urandom_range(0, 9) < 3) ? 4'($urandom_range(0, 15)) :
                                              4'($urandom_range(2, 5));
      end
      run_random_phase(chunk, sets_d, ways_d, lb_d);
      done += chunk;
      phase++;
    end

    $display("%0d accesses checked: %0d hits, %0d fills, %0d dirty evictions, %0d write-arounds",
             model.accesses_seen, model.hits_seen, model.fills_seen,
             model.dirty_evictions_seen, model.write_arounds_seen);
    $display("%0d register settings applied, %0d mismatches, %0d results missing",
             settings_applied, model.mismatch_count, model.pending());
    if (model.mismatch_count == 0 && model.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### set_assoc_cache_tag_policy.f
rtl/core/satc_pkg.sv
rtl/core/satc_cost.sv
rtl/core/set_assoc_cache_tag_policy.sv
sim/tb.sv
